// ===== hw/rtl/impq_pkg.sv =====
// shared types and constants for the indexed min priority queue
// no dependencies
package impq_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int COORD_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    CMD_UPSERT  = 3'd0,
    CMD_PEEK    = 3'd1,
    CMD_POP     = 3'd2,
    CMD_FIND    = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_REM_KEY = 3'd5,
    CMD_CLEAR   = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // per-cell control from the sequencer, same for every cell
  typedef struct packed {
    logic write_hit;   // replace key at the matching cell
    logic drop_hit;    // drop the matching cell
    logic drop_key;    // drop the matching cell if its key matches
    logic drop_min;    // drop the cell holding the minimum
    logic insert;      // lowest free cell takes the request
    logic clear;       // empty all cells
  } cell_ctl_t;

endpackage

// ===== hw/rtl/impq_cell.sv =====
// one storage cell of the queue: entry, match compare and a min-chain stage
// depends on impq_pkg
module impq_cell #(
  parameter int KEY_WIDTH   = impq_pkg::KEY_WIDTH_DEF,
  parameter int COORD_WIDTH = impq_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  impq_pkg::cell_ctl_t           ctl,
  input  logic signed [COORD_WIDTH-1:0] req_x,
  input  logic signed [COORD_WIDTH-1:0] req_y,
  input  logic [KEY_WIDTH-1:0]          req_k1,
  input  logic [KEY_WIDTH-1:0]          req_k2,
  input  logic                          free_in,
  output logic                          free_out,
  output logic                          hit,
  output logic                          key_eq,
  output logic                          valid,
  output logic [KEY_WIDTH-1:0]          ent_k1,
  output logic [KEY_WIDTH-1:0]          ent_k2,
  // running-minimum chain, one registered stage per cell
  input  logic                          min_shift,
  input  logic                          mv_in,
  input  logic signed [COORD_WIDTH-1:0] mx_in,
  input  logic signed [COORD_WIDTH-1:0] my_in,
  input  logic [KEY_WIDTH-1:0]          mk1_in,
  input  logic [KEY_WIDTH-1:0]          mk2_in,
  output logic                          mv,
  output logic signed [COORD_WIDTH-1:0] mx,
  output logic signed [COORD_WIDTH-1:0] my,
  output logic [KEY_WIDTH-1:0]          mk1,
  output logic [KEY_WIDTH-1:0]          mk2
);

  logic signed [COORD_WIDTH-1:0] ent_x;
  logic signed [COORD_WIDTH-1:0] ent_y;
  logic take;
  logic less;

  assign hit      = valid && ent_x == req_x && ent_y == req_y;
  assign key_eq   = ent_k1 == req_k1 && ent_k2 == req_k2;
  assign take     = !valid && free_in;
  assign free_out = free_in && valid;

  // this cell beats the incoming running minimum
  always_comb begin
    priority if (ent_k1 != mk1_in) less = ent_k1 < mk1_in;
    else if (ent_k2 != mk2_in)     less = ent_k2 < mk2_in;
    else if (ent_x != mx_in)       less = ent_x < mx_in;
    else                           less = ent_y < my_in;
  end

  // entry storage; a pop drops the cell whose coordinate matches the minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if ((ctl.drop_hit && hit) || (ctl.drop_key && hit && key_eq) ||
                 (ctl.drop_min && hit)) begin
      valid <= 1'b0;
    end else if (ctl.insert && take) begin
      valid <= 1'b1;
    end
    if ((ctl.insert && take) || (ctl.write_hit && hit)) begin
      ent_k1 <= req_k1;
      ent_k2 <= req_k2;
    end
    if (ctl.insert && take) begin
      ent_x <= req_x;
      ent_y <= req_y;
    end
  end

  // min chain stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (min_shift) begin
      if (valid && (!mv_in || less)) begin
        mv   <= 1'b1;
        mx   <= ent_x;
        my   <= ent_y;
        mk1  <= ent_k1;
        mk2  <= ent_k2;
      end else begin
        mv   <= mv_in;
        mx   <= mx_in;
        my   <= my_in;
        mk1  <= mk1_in;
        mk2  <= mk2_in;
      end
    end
  end

endmodule

// ===== hw/rtl/indexed_min_priority_queue_unit.sv =====
// top level: request sequencer, chain of storage cells and result register
// depends on impq_pkg and impq_cell
//
//  channel | signals                                              | dir
//  request | in_valid, in_stall, cmd, coord_x, coord_y,           | in
//          | key_primary, key_secondary                           |
//  result  | out_valid, out_stall, status, found, out_x, out_y,   | out
//          | out_primary, out_secondary, entry_count              |
//
// upsert, find, remove and clear: the exec state matches across all cells and
// updates them, and the result is registered at its end. peek and pop: exec,
// the walk state (the minimum moves one cell per cycle) and a done state; the
// result is registered at the end of the done state. one request at a time,
// and a waiting result stalls the next request. reset empties every cell at once.
module indexed_min_priority_queue_unit #(
  parameter int CAPACITY    = impq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH   = impq_pkg::KEY_WIDTH_DEF,
  parameter int COORD_WIDTH = impq_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    cmd,
  input  logic signed [COORD_WIDTH-1:0] coord_x,
  input  logic signed [COORD_WIDTH-1:0] coord_y,
  input  logic [KEY_WIDTH-1:0]          key_primary,
  input  logic [KEY_WIDTH-1:0]          key_secondary,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic                          found,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic [KEY_WIDTH-1:0]          out_primary,
  output logic [KEY_WIDTH-1:0]          out_secondary,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count
);

  localparam int CW = $clog2(CAPACITY+1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  impq_pkg::cmd_t                req_cmd;
  logic signed [COORD_WIDTH-1:0] req_x, req_y;
  logic signed [COORD_WIDTH-1:0] cell_x, cell_y;
  logic [KEY_WIDTH-1:0]          req_k1, req_k2;
  logic [CW-1:0]                 held_count;
  logic [CW-1:0]                 held_count_next;
  logic [CW-1:0]                 walk_cnt;
  impq_pkg::cell_ctl_t           ctl;

  logic [CAPACITY:0]   free_c;
  logic [CAPACITY:0]   mv_c;
  logic signed [COORD_WIDTH-1:0] mx_c [CAPACITY+1];
  logic signed [COORD_WIDTH-1:0] my_c [CAPACITY+1];
  logic [KEY_WIDTH-1:0]          mk1_c [CAPACITY+1];
  logic [KEY_WIDTH-1:0]          mk2_c [CAPACITY+1];
  logic [CAPACITY-1:0] hit_v, keq_v, valid_v;
  logic [KEY_WIDTH-1:0]          ek1_c [CAPACITY];
  logic [KEY_WIDTH-1:0]          ek2_c [CAPACITY];
  logic any_hit, hit_keq, min_shift;
  logic [KEY_WIDTH-1:0] hit_k1, hit_k2;

  logic                          res_load;
  logic [1:0]                    status_next;
  logic                          found_next;
  logic signed [COORD_WIDTH-1:0] out_x_next, out_y_next;
  logic [KEY_WIDTH-1:0]          out_primary_next, out_secondary_next;

  assign in_stall = state != S_IDLE || out_valid;
  assign free_c[0] = 1'b1;
  assign mv_c[0]   = 1'b0;
  assign mx_c[0]   = '0;
  assign my_c[0]   = '0;
  assign mk1_c[0]  = '0;
  assign mk2_c[0]  = '0;
  assign min_shift = state == S_WALK;

  // during the done cycle the cells match against the minimum found
  assign cell_x = (state == S_DONE) ? mx_c[CAPACITY] : req_x;
  assign cell_y = (state == S_DONE) ? my_c[CAPACITY] : req_y;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      impq_cell #(.KEY_WIDTH(KEY_WIDTH), .COORD_WIDTH(COORD_WIDTH)) u_cell (
        .clk, .rst, .ctl, .req_x(cell_x), .req_y(cell_y), .req_k1, .req_k2,
        .free_in(free_c[g]), .free_out(free_c[g+1]),
        .hit(hit_v[g]), .key_eq(keq_v[g]), .valid(valid_v[g]),
        .ent_k1(ek1_c[g]), .ent_k2(ek2_c[g]),
        .min_shift,
        .mv_in(mv_c[g]), .mx_in(mx_c[g]), .my_in(my_c[g]),
        .mk1_in(mk1_c[g]), .mk2_in(mk2_c[g]),
        .mv(mv_c[g+1]), .mx(mx_c[g+1]), .my(my_c[g+1]),
        .mk1(mk1_c[g+1]), .mk2(mk2_c[g+1])
      );
    end
  endgenerate

  // at most one cell hits, so an or-reduction selects its key
  always_comb begin
    any_hit = 1'b0;
    hit_keq = 1'b0;
    hit_k1  = '0;
    hit_k2  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_hit = any_hit | hit_v[i];
      hit_keq = hit_keq | (hit_v[i] & keq_v[i]);
      hit_k1  = hit_k1 | (ek1_c[i] & {KEY_WIDTH{hit_v[i]}});
      hit_k2  = hit_k2 | (ek2_c[i] & {KEY_WIDTH{hit_v[i]}});
    end
  end

  // cell commands during the exec cycle and, for a pop, the done cycle
  always_comb begin
    ctl = '0;
    if (state == S_EXEC) begin
      ctl.write_hit = req_cmd == impq_pkg::CMD_UPSERT;
      ctl.insert    = req_cmd == impq_pkg::CMD_UPSERT && !any_hit &&
                      held_count != CW'(CAPACITY);
      ctl.drop_hit  = req_cmd == impq_pkg::CMD_REMOVE;
      ctl.drop_key  = req_cmd == impq_pkg::CMD_REM_KEY;
      ctl.clear     = req_cmd == impq_pkg::CMD_CLEAR;
    end
    if (state == S_DONE) ctl.drop_min = req_cmd == impq_pkg::CMD_POP && mv_c[CAPACITY];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) state_next = S_EXEC;
      S_EXEC: begin
        if (req_cmd == impq_pkg::CMD_PEEK || req_cmd == impq_pkg::CMD_POP)
          state_next = S_WALK;
        else
          state_next = S_IDLE;
      end
      S_WALK: if (walk_cnt == CW'(CAPACITY - 1)) state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign res_load = (state == S_EXEC && state_next == S_IDLE) || state == S_DONE;

  // result and count for the request that finishes this cycle
  always_comb begin
    held_count_next    = held_count;
    status_next        = impq_pkg::ST_OK;
    found_next         = 1'b0;
    out_x_next         = '0;
    out_y_next         = '0;
    out_primary_next   = '0;
    out_secondary_next = '0;
    if (state == S_EXEC) begin
      unique case (req_cmd)
        impq_pkg::CMD_UPSERT: begin
          found_next = any_hit;
          if (!any_hit) begin
            if (held_count == CW'(CAPACITY)) status_next = impq_pkg::ST_FULL;
            else held_count_next = held_count + 1'b1;
          end
        end
        impq_pkg::CMD_FIND: begin
          found_next         = any_hit;
          out_primary_next   = hit_k1;
          out_secondary_next = hit_k2;
        end
        impq_pkg::CMD_REMOVE, impq_pkg::CMD_REM_KEY: begin
          if (any_hit && (req_cmd == impq_pkg::CMD_REMOVE || hit_keq)) begin
            found_next      = 1'b1;
            held_count_next = held_count - 1'b1;
          end
        end
        impq_pkg::CMD_CLEAR: held_count_next = '0;
        default: ;
      endcase
    end else if (state == S_DONE) begin
      found_next = mv_c[CAPACITY];
      if (mv_c[CAPACITY]) begin
        out_x_next         = mx_c[CAPACITY];
        out_y_next         = my_c[CAPACITY];
        out_primary_next   = mk1_c[CAPACITY];
        out_secondary_next = mk2_c[CAPACITY];
      end else begin
        status_next = impq_pkg::ST_NOT_FOUND;
      end
      if (ctl.drop_min) held_count_next = held_count - 1'b1;
    end
  end

  // sequencer, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_count <= '0;
      out_valid  <= 1'b0;
      walk_cnt   <= '0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == S_IDLE && in_valid && !in_stall) begin
        req_cmd  <= impq_pkg::cmd_t'(cmd);
        req_x    <= coord_x;
        req_y    <= coord_y;
        req_k1   <= key_primary;
        req_k2   <= key_secondary;
        walk_cnt <= '0;
      end
      if (state == S_WALK) walk_cnt <= walk_cnt + 1'b1;
      if (res_load) begin
        status        <= status_next;
        found         <= found_next;
        out_x         <= out_x_next;
        out_y         <= out_y_next;
        out_primary   <= out_primary_next;
        out_secondary <= out_secondary_next;
        entry_count   <= held_count_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_le_cap: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(CAPACITY)) else $error("held count above capacity");
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_v)) else $error("coordinate stored twice");
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> $countones(valid_v) == int'(held_count))
    else $error("held count disagrees with cell valids");
  a_min_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && mv_c[CAPACITY] |-> $onehot(hit_v))
    else $error("minimum entry not found in exactly one cell");
`endif

endmodule
